FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Plain invariant checked on every clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

`endif

FILE: rtl/sltdr_pkg.sv
// ----------------------------------------------------------------------------
// Slew limited tank drive package
// Register indexes, reset values and field widths of the drive core.
// ----------------------------------------------------------------------------
package sltdr_pkg;

    localparam int VEL_W  = 16;
    localparam int RPM_W  = 16;
    localparam int CFG_W  = 16;
    localparam int TICK_W = 5;

    localparam int                TIMEOUT_TICKS = 25;
    localparam logic [TICK_W-1:0] TICK_SAT      = 5'd31;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t REG_MAX_LINEAR  = 3'd0;
    localparam cfg_index_t REG_MAX_ANGULAR = 3'd1;
    localparam cfg_index_t REG_LINEAR_STEP = 3'd2;
    localparam cfg_index_t REG_ANG_STEP    = 3'd3;
    localparam cfg_index_t REG_MAX_RPM     = 3'd4;
    localparam cfg_index_t REG_HALF_TRACK  = 3'd5;
    localparam cfg_index_t REG_FRONT_GAIN  = 3'd6;
    localparam cfg_index_t REG_REAR_GAIN   = 3'd7;

    localparam logic [14:0] RST_MAX_LINEAR  = 15'd1024;
    localparam logic [14:0] RST_MAX_ANGULAR = 15'd2048;
    localparam logic [14:0] RST_LINEAR_STEP = 15'd10;
    localparam logic [14:0] RST_ANG_STEP    = 15'd20;
    localparam logic [14:0] RST_MAX_RPM     = 15'd1600;
    localparam logic [11:0] RST_HALF_TRACK  = 12'd1055;
    localparam logic [15:0] RST_FRONT_GAIN  = 16'd26288;
    localparam logic [15:0] RST_REAR_GAIN   = 16'd33036;

    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

endpackage

FILE: rtl/slew_limited_tank_drive_rpm_core.sv
// ----------------------------------------------------------------------------
// Slew limited tank drive RPM core
// Command clamping, timeout, slew limiting and wheel RPM scaling.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel. A command (opcode 0) clamps and stores
// the velocity targets in the cycle of its transfer and gives no result. A
// tick (opcode 1) runs through a small sequencer: slew limiting (S_SLEW),
// then five uses of a single shared 17 x 17 multiplier (the track offset and
// the four wheel speeds), each product registered before rounding and
// clamping, with the offset rounded (S_TRACK) and the track speeds formed
// (S_SPLIT) between the offset and the wheels. s_ready is low from the
// transfer of a tick until its result is loaded into the result register,
// so the core takes no new item while a tick is in work; commands are taken
// whenever the core is idle.
// The result register holds one finished tick. While the receiver stalls,
// commands are still taken; a later tick finishes its work and then waits
// until the pending result has been transferred.
// Configuration writes through cfg_wr_en, cfg_index and cfg_wdata take effect
// at the next clock edge and are meant for times when the core is idle.
// Synchronous reset restores the register reset values, clears targets,
// velocities and the tick count, and drops m_valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slew_limited_tank_drive_rpm_core import sltdr_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  cfg_index_t              cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_opcode,
    input  logic signed [VEL_W-1:0] s_cmd_linear,
    input  logic signed [VEL_W-1:0] s_cmd_angular,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [RPM_W-1:0] m_rpm_front_left,
    output logic signed [RPM_W-1:0] m_rpm_front_right,
    output logic signed [RPM_W-1:0] m_rpm_rear_left,
    output logic signed [RPM_W-1:0] m_rpm_rear_right,
    output logic                    m_command_timed_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLEW,
        S_MULW,
        S_TRACK,
        S_SPLIT,
        S_WHEEL,
        S_PUSH
    } state_t;

    state_t state_reg;

    logic [14:0] max_linear_reg;
    logic [14:0] max_angular_reg;
    logic [14:0] linear_step_reg;
    logic [14:0] angular_step_reg;
    logic [14:0] max_rpm_reg;
    logic [11:0] half_track_reg;
    logic [15:0] front_gain_reg;
    logic [15:0] rear_gain_reg;

    logic signed [VEL_W-1:0] tgt_lin_reg;
    logic signed [VEL_W-1:0] tgt_ang_reg;
    logic signed [VEL_W-1:0] cur_lin_reg;
    logic signed [VEL_W-1:0] cur_ang_reg;
    logic [TICK_W-1:0]       tick_cnt_reg;
    logic                    timed_out_reg;

    logic signed [16:0]      w_reg;
    logic signed [VEL_W-1:0] left_reg;
    logic signed [VEL_W-1:0] right_reg;
    logic signed [33:0]      prod_reg;
    logic [2:0]              wheel_cnt_reg;
    logic signed [RPM_W-1:0] rpm_reg [4];

    logic                    m_valid_reg;
    logic signed [RPM_W-1:0] m_fl_reg;
    logic signed [RPM_W-1:0] m_fr_reg;
    logic signed [RPM_W-1:0] m_rl_reg;
    logic signed [RPM_W-1:0] m_rr_reg;
    logic                    m_timed_out_reg;

    logic [TICK_W-1:0]       tick_cnt_next;
    logic signed [VEL_W-1:0] cmd_lin_next;
    logic signed [VEL_W-1:0] cmd_ang_next;
    logic signed [VEL_W-1:0] cur_lin_next;
    logic signed [VEL_W-1:0] cur_ang_next;
    logic signed [16:0]      mul_a;
    logic signed [16:0]      mul_b;
    logic signed [33:0]      mul_p;
    logic signed [33:0]      w_round;
    logic signed [33:0]      wheel_round;
    logic signed [16:0]      w_next;
    logic signed [VEL_W-1:0] left_next;
    logic signed [VEL_W-1:0] right_next;
    logic signed [RPM_W-1:0] rpm_next;
    logic signed [VEL_W-1:0] wheel_speed;
    logic [15:0]             wheel_gain;
    logic                    s_xfer;
    logic                    m_load;
    logic                    tick_xfer;
    logic                    slew_timeout;
    logic                    tgt_zero;

    function automatic logic signed [VEL_W-1:0] clamp_cmd(
        input logic signed [VEL_W-1:0] v,
        input logic [14:0]             lim
    );
        logic signed [VEL_W-1:0] l;
        l = $signed({1'b0, lim});
        if (v > l) begin
            return l;
        end else if (v < -l) begin
            return -l;
        end
        return v;
    endfunction

    function automatic logic signed [VEL_W-1:0] slew(
        input logic signed [VEL_W-1:0] cur,
        input logic signed [VEL_W-1:0] tgt,
        input logic [14:0]             step
    );
        logic signed [16:0] err;
        logic [16:0]        mag;
        logic signed [16:0] moved;
        err = {tgt[VEL_W-1], tgt} - {cur[VEL_W-1], cur};
        mag = err[16] ? 17'(-err) : 17'(err);
        if (mag > {2'b00, step}) begin
            if (err[16]) begin
                moved = {cur[VEL_W-1], cur} - $signed({2'b00, step});
            end else begin
                moved = {cur[VEL_W-1], cur} + $signed({2'b00, step});
            end
            return moved[VEL_W-1:0];
        end
        return tgt;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return v[VEL_W-1:0];
    endfunction

    assign s_xfer = s_valid && s_ready;
    assign m_load = (state_reg == S_PUSH) && (!m_valid_reg || m_ready);

    always_comb begin
        if (tick_cnt_reg < TICK_SAT) begin
            tick_cnt_next = tick_cnt_reg + 5'd1;
        end else begin
            tick_cnt_next = tick_cnt_reg;
        end
        cmd_lin_next = clamp_cmd(s_cmd_linear, max_linear_reg);
        cmd_ang_next = clamp_cmd(s_cmd_angular, max_angular_reg);
        cur_lin_next = slew(cur_lin_reg, tgt_lin_reg, linear_step_reg);
        cur_ang_next = slew(cur_ang_reg, tgt_ang_reg, angular_step_reg);
    end

    always_comb begin
        wheel_speed = wheel_cnt_reg[0] ? right_reg : left_reg;
        wheel_gain  = wheel_cnt_reg[1] ? rear_gain_reg : front_gain_reg;
        if (state_reg == S_MULW) begin
            mul_a = {cur_ang_reg[VEL_W-1], cur_ang_reg};
            mul_b = $signed({5'b00000, half_track_reg});
        end else begin
            mul_a = {wheel_speed[VEL_W-1], wheel_speed};
            mul_b = $signed({1'b0, wheel_gain});
        end
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        logic signed [19:0] r;
        logic signed [19:0] lim;
        w_round     = (prod_reg + 34'sd2048) >>> 12;
        wheel_round = (prod_reg + 34'sd8192) >>> 14;
        w_next      = w_round[16:0];
        left_next   = sat16({cur_lin_reg[VEL_W-1], cur_lin_reg[VEL_W-1], cur_lin_reg}
                            - {w_reg[16], w_reg});
        right_next  = sat16({cur_lin_reg[VEL_W-1], cur_lin_reg[VEL_W-1], cur_lin_reg}
                            + {w_reg[16], w_reg});
        r   = wheel_round[19:0];
        lim = $signed({5'b00000, max_rpm_reg});
        if (r > lim) begin
            rpm_next = lim[RPM_W-1:0];
        end else if (r < -lim) begin
            rpm_next = 16'(-lim);
        end else begin
            rpm_next = r[RPM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            max_linear_reg   <= RST_MAX_LINEAR;
            max_angular_reg  <= RST_MAX_ANGULAR;
            linear_step_reg  <= RST_LINEAR_STEP;
            angular_step_reg <= RST_ANG_STEP;
            max_rpm_reg      <= RST_MAX_RPM;
            half_track_reg   <= RST_HALF_TRACK;
            front_gain_reg   <= RST_FRONT_GAIN;
            rear_gain_reg    <= RST_REAR_GAIN;
            tgt_lin_reg      <= '0;
            tgt_ang_reg      <= '0;
            cur_lin_reg      <= '0;
            cur_ang_reg      <= '0;
            tick_cnt_reg     <= '0;
            timed_out_reg    <= 1'b0;
            wheel_cnt_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAX_LINEAR:  max_linear_reg   <= cfg_wdata[14:0];
                    REG_MAX_ANGULAR: max_angular_reg  <= cfg_wdata[14:0];
                    REG_LINEAR_STEP: linear_step_reg  <= cfg_wdata[14:0];
                    REG_ANG_STEP:    angular_step_reg <= cfg_wdata[14:0];
                    REG_MAX_RPM:     max_rpm_reg      <= cfg_wdata[14:0];
                    REG_HALF_TRACK:  half_track_reg   <= cfg_wdata[11:0];
                    REG_FRONT_GAIN:  front_gain_reg   <= cfg_wdata;
                    REG_REAR_GAIN:   rear_gain_reg    <= cfg_wdata;
                    default: ;
                endcase
            end

            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        if (s_opcode == OP_COMMAND) begin
                            tgt_lin_reg  <= cmd_lin_next;
                            tgt_ang_reg  <= cmd_ang_next;
                            tick_cnt_reg <= '0;
                        end else begin
                            tick_cnt_reg <= tick_cnt_next;
                            if (int'(tick_cnt_next) > TIMEOUT_TICKS) begin
                                tgt_lin_reg   <= '0;
                                tgt_ang_reg   <= '0;
                                timed_out_reg <= 1'b1;
                            end else begin
                                timed_out_reg <= 1'b0;
                            end
                            state_reg <= S_SLEW;
                        end
                    end
                end
                S_SLEW: begin
                    cur_lin_reg <= cur_lin_next;
                    cur_ang_reg <= cur_ang_next;
                    state_reg   <= S_MULW;
                end
                S_MULW: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_TRACK;
                end
                S_TRACK: begin
                    w_reg     <= w_next;
                    state_reg <= S_SPLIT;
                end
                S_SPLIT: begin
                    wheel_cnt_reg <= '0;
                    state_reg     <= S_WHEEL;
                end
                S_WHEEL: begin
                    prod_reg <= mul_p;
                    if (wheel_cnt_reg != 3'd0) begin
                        rpm_reg[2'(wheel_cnt_reg - 3'd1)] <= rpm_next;
                    end
                    if (wheel_cnt_reg == 3'd4) begin
                        state_reg <= S_PUSH;
                    end else begin
                        wheel_cnt_reg <= wheel_cnt_reg + 3'd1;
                    end
                end
                S_PUSH: begin
                    if (m_load) begin
                        m_fl_reg        <= rpm_reg[0];
                        m_fr_reg        <= rpm_reg[1];
                        m_rl_reg        <= rpm_reg[2];
                        m_rr_reg        <= rpm_reg[3];
                        m_timed_out_reg <= timed_out_reg;
                        wheel_cnt_reg   <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The track speeds are formed once the offset is known and stay put
    // while the shared multiplier walks through the four wheels.
    always_ff @(posedge aclk) begin
        if (state_reg == S_SPLIT) begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign s_ready             = (state_reg == S_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_rpm_front_left    = m_fl_reg;
    assign m_rpm_front_right   = m_fr_reg;
    assign m_rpm_rear_left     = m_rl_reg;
    assign m_rpm_rear_right    = m_rr_reg;
    assign m_command_timed_out = m_timed_out_reg;

    assign tick_xfer    = s_xfer && (s_opcode == OP_TICK);
    assign slew_timeout = (state_reg == S_SLEW) && timed_out_reg;
    assign tgt_zero     = (tgt_lin_reg == '0) && (tgt_ang_reg == '0);

    `ASSERT_ALWAYS(a_wheel_cnt_range, aclk, aresetn, wheel_cnt_reg <= 3'd4, "wheel count range")
    `ASSERT_CLK(a_timeout_zeroes, aclk, aresetn, slew_timeout |-> tgt_zero, "target not cleared")
    `ASSERT_CLK(a_tick_counts, aclk, aresetn, tick_xfer |=> (tick_cnt_reg != '0), "tick not counted")
    `ASSERT_CLK(a_result_push, aclk, aresetn, $rose(m_valid_reg) |-> $past(m_load), "stray result")

endmodule

FILE: verif/slew_limited_tank_drive_rpm_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slew limited tank drive RPM core testbench
// Drives velocity commands and control ticks with random gaps on both
// channels in most phases. The configuration changes between phases, from the reset values
// to the extremes and to random settings. A scoreboard predicts the clamped
// targets, the timeout, the slew limiting and the four wheel RPMs of every
// tick. Each result transfer is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module slew_limited_tank_drive_rpm_core_tb;
    import sltdr_pkg::*;

    typedef struct packed {
        logic signed [RPM_W-1:0] fl;
        logic signed [RPM_W-1:0] fr;
        logic signed [RPM_W-1:0] rl;
        logic signed [RPM_W-1:0] rr;
        logic                    timed_out;
    } wheel_rpm_t;

    class wheel_rpm_scoreboard;
        int          max_lin, max_ang, lin_step, ang_step, rpm_lim, half_trk;
        int          front_gain, rear_gain;
        int          tgt_lin, tgt_ang, cur_lin, cur_ang;
        int          tick_count;
        wheel_rpm_t  pending_rpm[$];
        int unsigned errors;

        function new();
            max_lin    = int'(RST_MAX_LINEAR);
            max_ang    = int'(RST_MAX_ANGULAR);
            lin_step   = int'(RST_LINEAR_STEP);
            ang_step   = int'(RST_ANG_STEP);
            rpm_lim    = int'(RST_MAX_RPM);
            half_trk   = int'(RST_HALF_TRACK);
            front_gain = int'(RST_FRONT_GAIN);
            rear_gain  = int'(RST_REAR_GAIN);
            tgt_lin    = 0;
            tgt_ang    = 0;
            cur_lin    = 0;
            cur_ang    = 0;
            tick_count = 0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_MAX_LINEAR:  max_lin    = int'(data[14:0]);
                REG_MAX_ANGULAR: max_ang    = int'(data[14:0]);
                REG_LINEAR_STEP: lin_step   = int'(data[14:0]);
                REG_ANG_STEP:    ang_step   = int'(data[14:0]);
                REG_MAX_RPM:     rpm_lim    = int'(data[14:0]);
                REG_HALF_TRACK:  half_trk   = int'(data[11:0]);
                REG_FRONT_GAIN:  front_gain = int'(data[15:0]);
                REG_REAR_GAIN:   rear_gain  = int'(data[15:0]);
                default: ;
            endcase
        endfunction

        function int clamp_sym(int v, int lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function int slew(int cur, int tgt, int step);
            int err;
            int mag;
            err = tgt - cur;
            mag = (err < 0) ? -err : err;
            if (mag > step) return (err > 0) ? cur + step : cur - step;
            return tgt;
        endfunction

        // Round to nearest with ties toward plus infinity.
        function longint round_shift(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function int sat16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return int'(v);
        endfunction

        function logic signed [RPM_W-1:0] wheel_speed(int speed, int gain);
            longint r;
            r = round_shift(longint'(speed) * longint'(gain), 14);
            if (r > rpm_lim) r = rpm_lim;
            if (r < -rpm_lim) r = -rpm_lim;
            return r[RPM_W-1:0];
        endfunction

        function void take_item(logic op, logic signed [VEL_W-1:0] lin,
                                logic signed [VEL_W-1:0] ang);
            wheel_rpm_t exp_rpm;
            int         w, left, right;
            if (op == OP_COMMAND) begin
                tgt_lin    = clamp_sym(int'(lin), max_lin);
                tgt_ang    = clamp_sym(int'(ang), max_ang);
                tick_count = 0;
                return;
            end
            exp_rpm.timed_out = 1'b0;
            if (tick_count < int'(TICK_SAT)) tick_count++;
            if (tick_count > int'(TIMEOUT_TICKS)) begin
                tgt_lin = 0;
                tgt_ang = 0;
                exp_rpm.timed_out = 1'b1;
            end
            cur_lin = slew(cur_lin, tgt_lin, lin_step);
            cur_ang = slew(cur_ang, tgt_ang, ang_step);
            w = int'(round_shift(longint'(cur_ang) * longint'(half_trk), 12));
            left  = sat16(longint'(cur_lin) - longint'(w));
            right = sat16(longint'(cur_lin) + longint'(w));
            exp_rpm.fl = wheel_speed(left, front_gain);
            exp_rpm.fr = wheel_speed(right, front_gain);
            exp_rpm.rl = wheel_speed(left, rear_gain);
            exp_rpm.rr = wheel_speed(right, rear_gain);
            pending_rpm.push_back(exp_rpm);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_wheels(wheel_rpm_t got);
            wheel_rpm_t exp_rpm;
            if (pending_rpm.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            exp_rpm = pending_rpm.pop_front();
            compare_field("rpm_front_left", int'(exp_rpm.fl), int'(got.fl));
            compare_field("rpm_front_right", int'(exp_rpm.fr), int'(got.fr));
            compare_field("rpm_rear_left", int'(exp_rpm.rl), int'(got.rl));
            compare_field("rpm_rear_right", int'(exp_rpm.rr), int'(got.rr));
            compare_field("command_timed_out", int'(exp_rpm.timed_out),
                          int'(got.timed_out));
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    cfg_index_t              cfg_index;
    logic [CFG_W-1:0]        cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_opcode;
    logic signed [VEL_W-1:0] s_cmd_linear;
    logic signed [VEL_W-1:0] s_cmd_angular;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [RPM_W-1:0] m_rpm_front_left;
    logic signed [RPM_W-1:0] m_rpm_front_right;
    logic signed [RPM_W-1:0] m_rpm_rear_left;
    logic signed [RPM_W-1:0] m_rpm_rear_right;
    logic                    m_command_timed_out;

    wheel_rpm_scoreboard board;
    bit                  idle_on;
    int unsigned         items_sent;

    slew_limited_tank_drive_rpm_core i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_cmd_linear        (s_cmd_linear),
        .s_cmd_angular       (s_cmd_angular),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_rpm_front_left    (m_rpm_front_left),
        .m_rpm_front_right   (m_rpm_front_right),
        .m_rpm_rear_left     (m_rpm_rear_left),
        .m_rpm_rear_right    (m_rpm_rear_right),
        .m_command_timed_out (m_command_timed_out)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.write_reg(idx, data);
    endtask

    task automatic push_item(logic op, logic [VEL_W-1:0] lin, logic [VEL_W-1:0] ang);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_opcode      = op;
        s_cmd_linear  = lin;
        s_cmd_angular = ang;
        do @(posedge aclk); while (!s_ready);
        board.take_item(op, lin, ang);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (board.pending_rpm.size() != 0) @(negedge aclk);
        repeat (15) @(negedge aclk);
    endtask

    function automatic logic [VEL_W-1:0] pick_velocity(int lim);
        case ($urandom_range(0, 3))
            0: return VEL_W'($urandom);
            1: return VEL_W'($urandom_range(0, 2 * lim + 20) - lim - 10);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
        endcase
    endfunction

    task automatic run_bursts(int unsigned n);
        int unsigned stop_at;
        int          ticks;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) != 0) begin
                push_item(OP_COMMAND, pick_velocity(board.max_lin),
                          pick_velocity(board.max_ang));
            end
            ticks = ($urandom_range(0, 7) == 0) ? int'($urandom_range(26, 40))
                                                : int'($urandom_range(0, 10));
            repeat (ticks) push_item(OP_TICK, VEL_W'($urandom), VEL_W'($urandom));
        end
    endtask

    task automatic write_all(logic [CFG_W-1:0] data);
        for (int i = 0; i < 8; i++) write_reg(cfg_index_t'(i), data);
    endtask

    task automatic write_random_config();
        for (int i = 0; i < 8; i++) begin
            write_reg(cfg_index_t'(i),
                      CFG_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 400)));
        end
    endtask

    initial begin
        int unsigned seen;
        bit          hold_done;
        seen      = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (idle_on) begin
                int gap;
                gap = int'($urandom_range(0, 5));
                if (gap > 0) begin
                    m_ready = 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            if (!hold_done && seen >= 120) begin
                hold_done = 1'b1;
                m_ready   = 1'b0;
                repeat (400) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_wheels('{m_rpm_front_left, m_rpm_front_right, m_rpm_rear_left,
                                 m_rpm_rear_right, m_command_timed_out});
            seen++;
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        board         = new();
        idle_on       = 1'b1;
        items_sent    = 0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_MAX_LINEAR;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_opcode      = OP_TICK;
        s_cmd_linear  = '0;
        s_cmd_angular = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        push_item(OP_TICK, 16'h0000, 16'h0000);
        push_item(OP_COMMAND, 16'h7FFF, 16'h7FFF);
        repeat (3) push_item(OP_TICK, 16'hFFFF, 16'hFFFF);
        push_item(OP_COMMAND, 16'h8000, 16'h8000);
        repeat (3) push_item(OP_TICK, 16'h0000, 16'h0000);
        push_item(OP_COMMAND, 16'h0000, 16'h0000);
        push_item(OP_TICK, 16'h0000, 16'h0000);
        push_item(OP_COMMAND, 16'hFFFF, 16'h0001);
        repeat (2) push_item(OP_TICK, 16'h0000, 16'h0000);
        push_item(OP_COMMAND, 16'd500, -16'sd300);
        push_item(OP_COMMAND, -16'sd1024, 16'sd2048);
        repeat (4) push_item(OP_TICK, 16'h0000, 16'h0000);
        run_bursts(200);
        drain();

        idle_on = 1'b0;
        write_all(16'hFFFF);
        push_item(OP_COMMAND, 16'h7FFF, 16'h8000);
        repeat (3) push_item(OP_TICK, 16'h0000, 16'h0000);
        push_item(OP_COMMAND, 16'h8000, 16'h7FFF);
        repeat (3) push_item(OP_TICK, 16'h0000, 16'h0000);
        run_bursts(190);
        drain();

        idle_on = 1'b1;
        write_all(16'h0000);
        run_bursts(100);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_random_config();
            run_bursts(220);
            drain();
        end

        while (board.pending_rpm.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
